>>> design/irmst_pkg.sv
// ----------------------------------------------------------------------------
// IR mark/space transmitter package
// Shared widths, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package irmst_pkg;

  localparam int STORE_DEPTH_DEF   = 256;
  localparam int DURATION_BITS_DEF = 20;

  localparam int CMD_W     = 2;
  localparam int CARRIER_W = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int ENTRIES_W = 9;

  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CARRIER_W-1:0] carrier_t;

  localparam cmd_t CMD_LOAD  = 2'd0;
  localparam cmd_t CMD_START = 2'd1;
  localparam cmd_t CMD_TICK  = 2'd2;
  localparam cmd_t CMD_ABORT = 2'd3;

  localparam cfg_idx_t CFG_CARRIER_HIGH = 2'd0;
  localparam cfg_idx_t CFG_CARRIER_LOW  = 2'd1;
  localparam cfg_idx_t CFG_ACTIVE_HIGH  = 2'd2;

  localparam carrier_t CARRIER_HIGH_RST = 16'd13;
  localparam carrier_t CARRIER_LOW_RST  = 16'd13;
  localparam logic     ACTIVE_HIGH_RST  = 1'b1;

endpackage

`default_nettype wire

>>> design/irmst_in_if.sv
// ----------------------------------------------------------------------------
// IR transmitter command channel
// Valid/ready channel carrying one command and its duration per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface irmst_in_if #(
  parameter int DUR_W = irmst_pkg::DURATION_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             cmd;
  logic [DUR_W-1:0]       duration_us;

  modport source (output valid, output cmd, output duration_us, input ready);
  modport sink   (input valid, input cmd, input duration_us, output ready);
endinterface

`default_nettype wire

>>> design/irmst_out_if.sv
// ----------------------------------------------------------------------------
// IR transmitter result channel
// Valid/ready channel carrying pin level and frame status per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface irmst_out_if;
  logic       valid;
  logic       ready;
  logic       pin_level;
  logic       busy_res;
  logic       frame_done;
  logic [8:0] entries_sent;
  logic       load_refused;

  modport source (output valid, output pin_level, output busy_res, output frame_done,
                  output entries_sent, output load_refused, input ready);
  modport sink   (input valid, input pin_level, input busy_res, input frame_done,
                  input entries_sent, input load_refused, output ready);
endinterface

`default_nettype wire

>>> design/ir_mark_space_transmitter.sv
// A load, abort, start-while-busy or idle tick goes from the beat to S_EMIT, then the output
// register. A modulated-mark tick passes S_TICK_A, S_TICK_B and, if a segment ends, S_TICK_C;
// other busy ticks go to S_EMIT. Entering an entry (start, or a tick ending one) passes S_SCAN
// and S_CHECK per entry read, zero-length ones included, then S_LOAD for a modulated mark's first
// segment; a frame that runs out closes in S_SCAN. One command at a time: ready is low until the
// result is queued. Reset clears control state, restores 13/13/1; store contents stay unknown.
// ----------------------------------------------------------------------------
// IR mark/space transmitter
// Stores a frame of microsecond durations and drives the IR pin once per tick,
// chopping marks into carrier segments with a shared segment length unit.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_mark_space_transmitter #(
  parameter int STORE_DEPTH   = irmst_pkg::STORE_DEPTH_DEF,
  parameter int DURATION_BITS = irmst_pkg::DURATION_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  irmst_in_if.sink                   in_ch,
  irmst_out_if.source                out_ch,
  input  wire logic                  cfg_we,
  input  wire irmst_pkg::cfg_idx_t   cfg_index,
  input  wire logic [irmst_pkg::CFG_W-1:0] cfg_data
);
  import irmst_pkg::*;

  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int DUR_W  = DURATION_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_LOAD   = 3'd3;
  localparam logic [2:0] S_TICK_A = 3'd4;
  localparam logic [2:0] S_TICK_B = 3'd5;
  localparam logic [2:0] S_TICK_C = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]       state;

  carrier_t         carrier_high;
  carrier_t         carrier_low;
  logic             active_high;

  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] entry_index;
  logic [DUR_W-1:0] entry_remaining;
  logic [DUR_W-1:0] segment_left;
  logic             carrier_phase;
  logic             sending;
  logic             done_flag;
  logic             refused_flag;

  logic             out_valid;
  logic             out_free;
  logic             modulated;
  logic             is_mark;
  logic             carrier_on;
  logic             in_acc;
  logic             store_full;

  logic [DUR_W-1:0] seg_min_out;
  logic [DUR_W-1:0] rem_dec;
  logic [DUR_W-1:0] seg_dec;

  logic             st_we;
  logic             st_re;
  logic [DUR_W-1:0] st_rdata;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_high <= CARRIER_HIGH_RST;
      carrier_low  <= CARRIER_LOW_RST;
      active_high  <= ACTIVE_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CARRIER_HIGH: carrier_high <= cfg_data[CARRIER_W-1:0];
        CFG_CARRIER_LOW:  carrier_low  <= cfg_data[CARRIER_W-1:0];
        CFG_ACTIVE_HIGH:  active_high  <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  assign modulated  = (carrier_high != '0) && (carrier_low != '0);
  assign is_mark    = ~entry_index[0];
  assign carrier_on = sending && is_mark && (!modulated || carrier_phase);
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign store_full = (entry_count >= CNT_W'(STORE_DEPTH));
  assign out_free   = !out_valid || out_ch.ready;
  assign rem_dec    = (entry_remaining != '0) ? entry_remaining - 1'b1 : entry_remaining;
  assign seg_dec    = (segment_left != '0) ? segment_left - 1'b1 : segment_left;

  assign in_ch.ready = (state == S_IDLE);

  irmst_seg_min #(.DUR_W(DUR_W)) u_seg_min (
    .phase        (carrier_phase),
    .carrier_high (carrier_high),
    .carrier_low  (carrier_low),
    .remaining    (entry_remaining),
    .seg_len      (seg_min_out)
  );

  assign st_we = in_acc && (in_ch.cmd == CMD_LOAD) && !sending && !store_full;
  assign st_re = (state == S_SCAN) && (entry_index < entry_count);

  irmst_store #(.DEPTH(STORE_DEPTH), .DW(DUR_W), .AW(ADDR_W)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (entry_count[ADDR_W-1:0]),
    .wdata (in_ch.duration_us),
    .re    (st_re),
    .raddr (entry_index[ADDR_W-1:0]),
    .rdata (st_rdata)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      entry_count     <= '0;
      entry_index     <= '0;
      entry_remaining <= '0;
      segment_left    <= '0;
      carrier_phase   <= 1'b0;
      sending         <= 1'b0;
      done_flag       <= 1'b0;
      refused_flag    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            done_flag    <= 1'b0;
            refused_flag <= 1'b0;
            state        <= S_EMIT;
            case (in_ch.cmd)
              CMD_LOAD: begin
                if (sending || store_full) begin
                  refused_flag <= 1'b1;
                end else begin
                  entry_count <= entry_count + 1'b1;
                end
              end
              CMD_START: begin
                if (!sending) begin
                  sending       <= 1'b1;
                  entry_index   <= '0;
                  carrier_phase <= 1'b0;
                  state         <= S_SCAN;
                end
              end
              CMD_TICK: begin
                if (sending) begin
                  if (is_mark && modulated) begin
                    state <= S_TICK_A;
                  end else begin
                    segment_left    <= '0;
                    entry_remaining <= rem_dec;
                    if (rem_dec == '0) begin
                      entry_index <= entry_index + 1'b1;
                      state       <= S_SCAN;
                    end
                  end
                end
              end
              CMD_ABORT: begin
                done_flag       <= sending;
                sending         <= 1'b0;
                entry_count     <= '0;
                entry_remaining <= '0;
                segment_left    <= '0;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          // walk the store one read at a time; running off the end closes the frame
          if (entry_index < entry_count) begin
            state <= S_CHECK;
          end else begin
            sending         <= 1'b0;
            entry_count     <= '0;
            entry_remaining <= '0;
            segment_left    <= '0;
            done_flag       <= 1'b1;
            state           <= S_EMIT;
          end
        end
        S_CHECK: begin
          if (st_rdata == '0) begin
            entry_index <= entry_index + 1'b1;
            state       <= S_SCAN;
          end else begin
            entry_remaining <= st_rdata;
            segment_left    <= '0;
            state           <= (is_mark && modulated) ? S_LOAD : S_EMIT;
          end
        end
        S_LOAD: begin
          segment_left <= seg_min_out;
          state        <= S_EMIT;
        end
        S_TICK_A: begin
          if (segment_left == '0) begin
            segment_left <= seg_min_out;
          end
          state <= S_TICK_B;
        end
        S_TICK_B: begin
          segment_left    <= seg_dec;
          entry_remaining <= rem_dec;
          if (seg_dec == '0) begin
            carrier_phase <= ~carrier_phase;
          end
          if (rem_dec == '0) begin
            entry_index <= entry_index + 1'b1;
            state       <= S_SCAN;
          end else if (seg_dec == '0) begin
            state <= S_TICK_C;
          end else begin
            state <= S_EMIT;
          end
        end
        S_TICK_C: begin
          // reload with the flipped phase against the updated remainder
          segment_left <= seg_min_out;
          state        <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_ch.pin_level    <= (carrier_on == active_high);
      out_ch.busy_res     <= sending;
      out_ch.frame_done   <= done_flag;
      out_ch.entries_sent <= ENTRIES_W'(entry_index);
      out_ch.load_refused <= refused_flag;
    end
  end

  assign out_ch.valid = out_valid;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(STORE_DEPTH))
    else $error("entry count beyond store depth");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ch.frame_done |-> !out_ch.busy_res)
    else $error("frame done reported while still busy");

  a_done_refused: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_ch.frame_done && out_ch.load_refused))
    else $error("frame done and load refused on one beat");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ch.ready)
    else $error("new beat taken while a command is in flight");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> sending && (entry_index < entry_count))
    else $error("store read outside the loaded frame");

endmodule

`default_nettype wire

>>> design/irmst_store.sv
// ----------------------------------------------------------------------------
// Duration store
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module irmst_store #(
  parameter int DEPTH = irmst_pkg::STORE_DEPTH_DEF,
  parameter int DW    = irmst_pkg::DURATION_BITS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/irmst_seg_min.sv
// ----------------------------------------------------------------------------
// Carrier segment length unit
// Picks the carrier time for the current phase and clips it to what remains.
// ----------------------------------------------------------------------------
`default_nettype none

module irmst_seg_min #(
  parameter int DUR_W = irmst_pkg::DURATION_BITS_DEF
) (
  input  wire logic                     phase,
  input  wire irmst_pkg::carrier_t      carrier_high,
  input  wire irmst_pkg::carrier_t      carrier_low,
  input  wire logic [DUR_W-1:0]         remaining,
  output logic      [DUR_W-1:0]         seg_len
);
  import irmst_pkg::*;

  localparam int CMP_W = (DUR_W > CARRIER_W) ? DUR_W : CARRIER_W;

  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] rem_ext;

  always_comb begin
    len_ext = CMP_W'(phase ? carrier_high : carrier_low);
    rem_ext = CMP_W'(remaining);
    seg_len = (len_ext < rem_ext) ? DUR_W'(len_ext) : remaining;
  end

endmodule

`default_nettype wire
